### sv/baro_temp_pressure_compensation_top_assert.svh
// Assertion macros for the barometric compensation block checker.
// Used by the bound checker module; needs a clock and an active-low reset.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset
`define BTPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("btpc assertion failed");

// Next-cycle implication, held off during reset
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("btpc assertion failed");

`endif

### sv/btpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; imported by every module of the block.
package btpc_pkg;

	localparam int RAW_W     = 20;
	localparam int TEMP_W    = 15;
	localparam int PRES_W    = 32;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int V1P_W     = 27;

	// divider: one quotient bit per restoring step
	localparam int DIV_W         = 64;
	localparam int DIV_STAGES    = 32;
	localparam int DIV_STEP_BITS = DIV_W / DIV_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_T  = 2'd0,
		CFG_CAL_PL = 2'd1,
		CFG_CAL_PH = 2'd2,
		CFG_CAL_P9 = 2'd3
	} cfg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_TEMP_RANGE = 2'd1,
		ST_PRES_RANGE = 2'd2,
		ST_DIV_ZERO   = 2'd3
	} status_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} btpc_cal_t;

	// per-word flags that ride along the pipeline
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     tsat;
		logic                     dzero;
		logic                     qneg;
	} btpc_side_t;

	localparam logic signed [20:0]       TEMP_HI     = 21'sd10000;
	localparam logic signed [20:0]       TEMP_LO     = -21'sd10000;
	localparam logic signed [TEMP_W-1:0] TEMP_SAT_HI = 15'sd10000;
	localparam logic signed [TEMP_W-1:0] TEMP_SAT_LO = -15'sd10000;
	localparam logic signed [V1P_W-1:0]  TFINE_OFS   = 27'sd128000;
	localparam logic [20:0]              RAW_FULL    = 21'd1048576;
	localparam logic [11:0]              NUM_SCALE   = 12'd3125;
	localparam logic [63:0]              VAR1_BIAS   = 64'h0000_8000_0000_0000;
	localparam logic signed [63:0]       P_MIN_Q8    = 64'sd20480000;
	localparam logic signed [63:0]       P_MAX_Q8    = 64'sd30720000;
	localparam logic [PRES_W-1:0]        PRES_LO_Q8  = 32'd20480000;
	localparam logic [PRES_W-1:0]        PRES_HI_Q8  = 32'd30720000;

endpackage

### sv/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps
// Barometric temperature and pressure compensation, top level.
// Depends on btpc_pkg, btpc_temp, btpc_pre, btpc_div and btpc_post.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word of raw temperature and
//   raw pressure. Output channel (out_valid/out_ready) returns temperature
//   in 0.01 degC, pressure in Pa Q24.8 and a status code.
//   Calibration words are written through cfg_write/cfg_addr/cfg_wdata while
//   no word is in flight; index 0 temperature words, 1 and 2 pressure words
//   one to eight, 3 pressure word nine.
// Throughput: one word per cycle while the output is not stalled.
// Pipeline: the accepting edge loads the input register, then come
//   3 temperature stages, 8 pressure stages, 32 divider stages (two
//   quotient bits each, 64 in all) and 8 post-division stages ending
//   in the output register.
// Reset clears all valid bits and calibration registers; no clearing pass.
// Stall: when out_valid is high and out_ready low the whole pipeline holds;
//   the input register still takes one word if it is empty.
module baro_temp_pressure_compensation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [btpc_pkg::RAW_W-1:0]          raw_temperature,
	input  logic [btpc_pkg::RAW_W-1:0]          raw_pressure,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [btpc_pkg::TEMP_W-1:0]  temperature_centi,
	output logic [btpc_pkg::PRES_W-1:0]         pressure_fixed,
	output logic [btpc_pkg::STAT_W-1:0]         status,
	input  logic                                cfg_write,
	input  logic [btpc_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [btpc_pkg::CFG_W-1:0]          cfg_wdata
);
	import btpc_pkg::*;

	logic [47:0] cal_t_q;
	logic [63:0] cal_pl_q;
	logic [63:0] cal_ph_q;
	logic [15:0] cal_p9_q;
	btpc_cal_t cal;

	logic adv;
	logic v_s1;
	logic [RAW_W-1:0] rt_s1, rp_s1;

	logic t_v;
	logic [RAW_W-1:0] t_rp;
	logic signed [V1P_W-1:0] t_v1p;
	btpc_side_t t_side;

	logic p_v;
	logic [DIV_W-1:0] p_mag;
	logic [30:0] p_dvs;
	btpc_side_t p_side;

	logic d_v;
	logic [DIV_W-1:0] d_quo;
	btpc_side_t d_side;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q  <= '0;
			cal_pl_q <= '0;
			cal_ph_q <= '0;
			cal_p9_q <= '0;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_CAL_T:  cal_t_q  <= cfg_wdata[47:0];
				CFG_CAL_PL: cal_pl_q <= cfg_wdata;
				CFG_CAL_PH: cal_ph_q <= cfg_wdata;
				CFG_CAL_P9: cal_p9_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// unpack calibration words
	always_comb begin
		cal.t1 = cal_t_q[15:0];
		cal.t2 = cal_t_q[31:16];
		cal.t3 = cal_t_q[47:32];
		cal.p1 = cal_pl_q[15:0];
		cal.p2 = cal_pl_q[31:16];
		cal.p3 = cal_pl_q[47:32];
		cal.p4 = cal_pl_q[63:48];
		cal.p5 = cal_ph_q[15:0];
		cal.p6 = cal_ph_q[31:16];
		cal.p7 = cal_ph_q[47:32];
		cal.p8 = cal_ph_q[63:48];
		cal.p9 = cal_p9_q;
	end

	// advance whenever the output register is free or being taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv || !v_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rt_s1 <= raw_temperature;
			rp_s1 <= raw_pressure;
		end
	end

	btpc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.v_in      (v_s1),
		.raw_t     (rt_s1),
		.raw_p     (rp_s1),
		.cal       (cal),
		.v_out     (t_v),
		.raw_p_out (t_rp),
		.v1p_out   (t_v1p),
		.side_out  (t_side)
	);

	btpc_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (t_v),
		.v1p      (t_v1p),
		.raw_p    (t_rp),
		.side_in  (t_side),
		.cal      (cal),
		.v_out    (p_v),
		.mag_out  (p_mag),
		.dvs_out  (p_dvs),
		.side_out (p_side)
	);

	btpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (p_v),
		.mag_in   (p_mag),
		.dvs_in   (p_dvs),
		.side_in  (p_side),
		.v_out    (d_v),
		.quo_out  (d_quo),
		.side_out (d_side)
	);

	btpc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (d_v),
		.quo_in   (d_quo),
		.side_in  (d_side),
		.cal      (cal),
		.v_out    (out_valid),
		.temp_out (temperature_centi),
		.pres_out (pressure_fixed),
		.stat_out (status)
	);

endmodule

### sv/btpc_temp.sv
`timescale 1ns / 1ps
// Temperature compensation: three stages from raw temperature to t_fine,
// saturated temperature and the pressure offset term. Uses btpc_pkg.
module btpc_temp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             v_in,
	input  logic [btpc_pkg::RAW_W-1:0]       raw_t,
	input  logic [btpc_pkg::RAW_W-1:0]       raw_p,
	input  btpc_pkg::btpc_cal_t              cal,
	output logic                             v_out,
	output logic [btpc_pkg::RAW_W-1:0]       raw_p_out,
	output logic signed [btpc_pkg::V1P_W-1:0] v1p_out,
	output btpc_pkg::btpc_side_t             side_out
);
	import btpc_pkg::*;

	logic signed [17:0] a_c;
	logic signed [33:0] at_c;
	logic signed [16:0] d_c;
	logic signed [33:0] dsq_c;
	logic signed [38:0] v2t_c;
	logic signed [25:0] tfine_c;
	logic signed [28:0] t5_c;
	logic signed [20:0] tc_c;
	logic signed [TEMP_W-1:0] temp_c;
	logic tsat_c;
	logic signed [V1P_W-1:0] v1p_c;

	logic [2:0] v_s;
	logic signed [22:0] v1t_s1;
	logic [21:0] dsq12_s1;
	logic [RAW_W-1:0] rp_s1, rp_s2, rp_s3;
	logic signed [25:0] tfine_s2;
	logic signed [V1P_W-1:0] v1p_s3;
	btpc_side_t side_s3;

	// stage 1: linear and square terms
	always_comb begin
		a_c   = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
		at_c  = a_c * $signed(cal.t2);
		d_c   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cal.t1});
		dsq_c = d_c * d_c;
	end

	// stage 2: fine temperature
	always_comb begin
		v2t_c   = $signed({1'b0, dsq12_s1}) * $signed(cal.t3);
		tfine_c = 26'(v1t_s1) + 26'(v2t_c >>> 14);
	end

	// stage 3: scale to centidegrees and clamp
	always_comb begin
		t5_c  = tfine_s2 * 29'sd5 + 29'sd128;
		tc_c  = 21'(t5_c >>> 8);
		v1p_c = 27'(tfine_s2) - TFINE_OFS;
		if (tc_c > TEMP_HI) begin
			temp_c = TEMP_SAT_HI;
			tsat_c = 1'b1;
		end else if (tc_c < TEMP_LO) begin
			temp_c = TEMP_SAT_LO;
			tsat_c = 1'b1;
		end else begin
			temp_c = tc_c[TEMP_W-1:0];
			tsat_c = 1'b0;
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[1:0], v_in};
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			v1t_s1        <= 23'(at_c >>> 11);
			dsq12_s1      <= dsq_c[33:12];
			rp_s1         <= raw_p;
			tfine_s2      <= tfine_c;
			rp_s2         <= rp_s1;
			v1p_s3        <= v1p_c;
			rp_s3         <= rp_s2;
			side_s3.temp  <= temp_c;
			side_s3.tsat  <= tsat_c;
			side_s3.dzero <= 1'b0;
			side_s3.qneg  <= 1'b0;
		end
	end

	assign v_out     = v_s[2];
	assign raw_p_out = rp_s3;
	assign v1p_out   = v1p_s3;
	assign side_out  = side_s3;

endmodule

### sv/btpc_pre.sv
`timescale 1ns / 1ps
// Pressure terms ahead of the division: eight stages producing the
// dividend and divisor magnitudes and the sign of the quotient. Uses btpc_pkg.
module btpc_pre (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              v_in,
	input  logic signed [btpc_pkg::V1P_W-1:0] v1p,
	input  logic [btpc_pkg::RAW_W-1:0]        raw_p,
	input  btpc_pkg::btpc_side_t              side_in,
	input  btpc_pkg::btpc_cal_t               cal,
	output logic                              v_out,
	output logic [btpc_pkg::DIV_W-1:0]        mag_out,
	output logic [30:0]                       dvs_out,
	output btpc_pkg::btpc_side_t              side_out
);
	import btpc_pkg::*;

	logic signed [53:0] sq_c;
	logic signed [42:0] m5_c, m2_c;
	logic signed [43:0] a6l_c, a6h_c, a3l_c, a3h_c;
	logic [63:0] pp6_c, pp3_c;
	logic signed [63:0] pp3_sh;
	logic [63:0] v2_c, v1a_c;
	logic [20:0] pc_c;
	logic [63:0] x_c, n0_c;
	logic [47:0] xl_c;
	logic [31:0] xh_c, nh_c;
	logic [43:0] nl_c;
	logic [63:0] prod_c, num_c;
	logic [63:0] mn_c;
	logic [30:0] md_c;

	logic [7:0] v_s;
	btpc_side_t side_s [8];
	logic [RAW_W-1:0] rp_s [3];
	logic signed [53:0] sq_s1;
	logic signed [42:0] m5_s1, m2_s1, m5_s2, m2_s2, m5_s3, m2_s3;
	logic signed [43:0] a6l_s2, a6h_s2, a3l_s2, a3h_s2;
	logic [63:0] pp6_s3, pp3_s3;
	logic [63:0] v2_s4, v1a_s4;
	logic [20:0] pc_s4;
	logic [63:0] x_s5, n0_s5;
	logic [47:0] xl_s6;
	logic [31:0] xh_s6, nh_s6;
	logic [43:0] nl_s6;
	logic [63:0] num_s7;
	logic signed [30:0] dvs_s7;
	logic [63:0] mn_s8;
	logic [30:0] md_s8;

	// stage 1: square and linear products of the offset temperature
	always_comb begin
		sq_c = v1p * v1p;
		m5_c = v1p * $signed(cal.p5);
		m2_c = v1p * $signed(cal.p2);
	end

	// stage 2: split square times the quadratic coefficients
	always_comb begin
		a6l_c = $signed({1'b0, sq_s1[26:0]}) * $signed(cal.p6);
		a6h_c = $signed({1'b0, sq_s1[53:27]}) * $signed(cal.p6);
		a3l_c = $signed({1'b0, sq_s1[26:0]}) * $signed(cal.p3);
		a3h_c = $signed({1'b0, sq_s1[53:27]}) * $signed(cal.p3);
	end

	// stage 3: recombine partial products modulo 2^64
	always_comb begin
		pp6_c = ({{20{a6h_s2[43]}}, a6h_s2} << 27) + {{20{a6l_s2[43]}}, a6l_s2};
		pp3_c = ({{20{a3h_s2[43]}}, a3h_s2} << 27) + {{20{a3l_s2[43]}}, a3l_s2};
	end

	// stage 4: var2 and var1 sums
	assign pp3_sh = $signed(pp3_s3) >>> 8;
	always_comb begin
		v2_c  = pp6_s3 + ({{21{m5_s3[42]}}, m5_s3} << 17)
			+ ({{48{cal.p4[15]}}, cal.p4} << 35);
		v1a_c = pp3_sh + ({{21{m2_s3[42]}}, m2_s3} << 12);
		pc_c  = RAW_FULL - {1'b0, rp_s[2]};
	end

	// stage 5: bias var1, form the unscaled dividend
	always_comb begin
		x_c  = v1a_s4 + VAR1_BIAS;
		n0_c = {12'd0, pc_s4, 31'd0} - v2_s4;
	end

	// stage 6: scale both by their constants in 32-bit halves
	always_comb begin
		xl_c = x_s5[31:0] * cal.p1;
		xh_c = x_s5[63:32] * {16'd0, cal.p1};
		nl_c = n0_s5[31:0] * NUM_SCALE;
		nh_c = n0_s5[63:32] * {20'd0, NUM_SCALE};
	end

	// stage 7: recombine halves
	always_comb begin
		prod_c = {xh_s6, 32'd0} + {16'd0, xl_s6};
		num_c  = {nh_s6, 32'd0} + {20'd0, nl_s6};
	end

	// stage 8: magnitudes and sign of the quotient
	always_comb begin
		mn_c = num_s7[63] ? (64'd0 - num_s7) : num_s7;
		md_c = dvs_s7[30] ? (31'd0 - dvs_s7) : dvs_s7;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[6:0], v_in};
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < 7; k++) begin
				side_s[k] <= side_s[k-1];
			end
			side_s[7].temp  <= side_s[6].temp;
			side_s[7].tsat  <= side_s[6].tsat;
			side_s[7].dzero <= (dvs_s7 == 31'sd0);
			side_s[7].qneg  <= num_s7[63] ^ dvs_s7[30];
			rp_s[0] <= raw_p;
			for (int k = 1; k < 3; k++) begin
				rp_s[k] <= rp_s[k-1];
			end
			sq_s1  <= sq_c;
			m5_s1  <= m5_c;
			m2_s1  <= m2_c;
			a6l_s2 <= a6l_c;
			a6h_s2 <= a6h_c;
			a3l_s2 <= a3l_c;
			a3h_s2 <= a3h_c;
			m5_s2  <= m5_s1;
			m2_s2  <= m2_s1;
			pp6_s3 <= pp6_c;
			pp3_s3 <= pp3_c;
			m5_s3  <= m5_s2;
			m2_s3  <= m2_s2;
			v2_s4  <= v2_c;
			v1a_s4 <= v1a_c;
			pc_s4  <= pc_c;
			x_s5   <= x_c;
			n0_s5  <= n0_c;
			xl_s6  <= xl_c;
			xh_s6  <= xh_c;
			nl_s6  <= nl_c;
			nh_s6  <= nh_c;
			num_s7 <= num_c;
			dvs_s7 <= prod_c[63:33];
			mn_s8  <= mn_c;
			md_s8  <= md_c;
		end
	end

	assign v_out    = v_s[7];
	assign mag_out  = mn_s8;
	assign dvs_out  = md_s8;
	assign side_out = side_s[7];

endmodule

### sv/btpc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, unsigned 64-bit by 31-bit, two quotient
// bits per stage. Uses btpc_pkg for widths and the side-band word type.
module btpc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       v_in,
	input  logic [btpc_pkg::DIV_W-1:0] mag_in,
	input  logic [30:0]                dvs_in,
	input  btpc_pkg::btpc_side_t       side_in,
	output logic                       v_out,
	output logic [btpc_pkg::DIV_W-1:0] quo_out,
	output btpc_pkg::btpc_side_t       side_out
);
	import btpc_pkg::*;

	typedef struct packed {
		logic [31:0]      rem;
		logic [DIV_W-1:0] dq;
	} div_work_t;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic div_work_t div_step(input div_work_t w, input logic [30:0] dvs);
		logic [32:0] trial;
		logic        ge;
		div_work_t   r;
		trial = {w.rem, w.dq[DIV_W-1]};
		ge    = (trial >= {2'b00, dvs});
		r.rem = ge ? 32'(trial - {2'b00, dvs}) : trial[31:0];
		r.dq  = {w.dq[DIV_W-2:0], ge};
		return r;
	endfunction

	logic [DIV_STAGES-1:0] v_s;
	div_work_t  work_s [DIV_STAGES];
	logic [30:0] dvs_s [DIV_STAGES];
	btpc_side_t side_s [DIV_STAGES];

	div_work_t  work_src [DIV_STAGES];
	logic [30:0] dvs_src [DIV_STAGES];
	btpc_side_t side_src [DIV_STAGES];
	div_work_t  work_nxt [DIV_STAGES];
	div_work_t  w;

	// stage inputs: the first stage takes the new word
	always_comb begin
		work_src[0] = {32'd0, mag_in};
		dvs_src[0]  = dvs_in;
		side_src[0] = side_in;
		for (int k = 1; k < DIV_STAGES; k++) begin
			work_src[k] = work_s[k-1];
			dvs_src[k]  = dvs_s[k-1];
			side_src[k] = side_s[k-1];
		end
	end

	// each stage runs its own steps
	always_comb begin
		w = '0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			w = work_src[k];
			for (int b = 0; b < DIV_STEP_BITS; b++) begin
				w = div_step(w, dvs_src[k]);
			end
			work_nxt[k] = w;
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[DIV_STAGES-2:0], v_in};
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				work_s[k] <= work_nxt[k];
				dvs_s[k]  <= dvs_src[k];
				side_s[k] <= side_src[k];
			end
		end
	end

	assign v_out    = v_s[DIV_STAGES-1];
	assign quo_out  = work_s[DIV_STAGES-1].dq;
	assign side_out = side_s[DIV_STAGES-1];

endmodule

### sv/btpc_post.sv
`timescale 1ns / 1ps
// Pressure terms after the division, range checks and the output register.
// Eight stages; uses btpc_pkg.
module btpc_post (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              v_in,
	input  logic [btpc_pkg::DIV_W-1:0]        quo_in,
	input  btpc_pkg::btpc_side_t              side_in,
	input  btpc_pkg::btpc_cal_t               cal,
	output logic                              v_out,
	output logic signed [btpc_pkg::TEMP_W-1:0] temp_out,
	output logic [btpc_pkg::PRES_W-1:0]       pres_out,
	output logic [btpc_pkg::STAT_W-1:0]       stat_out
);
	import btpc_pkg::*;

	logic [63:0] q_c;
	logic signed [63:0] s_c;
	logic [63:0] ll_c;
	logic [31:0] lh_c, p8h_c, p9h_c;
	logic signed [48:0] p8l_c, p9l_c;
	logic [63:0] ss_c, v2s_c, ssp9_c;
	logic signed [63:0] v2b_c, v1c_c, sh_c;
	logic [63:0] sum_c, pfin_c;
	logic signed [63:0] pf;
	status_t st_c;
	logic [PRES_W-1:0] pres_c;

	logic [7:0] v_s;
	btpc_side_t side_s [7];
	logic [63:0] q_s [5];
	logic [63:0] ll_s2;
	logic [31:0] lh_s2, p8h_s2, p9h_s4;
	logic signed [48:0] p8l_s2, p9l_s4;
	logic [63:0] ss_s3;
	logic [63:0] v2b_s [3];
	logic [63:0] ssp9_s5, sum_s6, pfin_s7;
	logic signed [TEMP_W-1:0] temp_s8;
	logic [PRES_W-1:0] pres_s8;
	status_t st_s8;

	// stage 1: signed quotient
	assign q_c = side_in.qneg ? (64'd0 - quo_in) : quo_in;

	// stage 2: square of the scaled pressure, p8 product, in 32-bit halves
	assign s_c = $signed(q_s[0]) >>> 13;
	always_comb begin
		ll_c  = s_c[31:0] * s_c[31:0];
		lh_c  = s_c[31:0] * s_c[63:32];
		p8l_c = $signed({1'b0, q_s[0][31:0]}) * $signed(cal.p8);
		p8h_c = q_s[0][63:32] * {{16{cal.p8[15]}}, cal.p8};
	end

	// stage 3: recombine
	always_comb begin
		ss_c  = ll_s2 + {lh_s2[30:0], 33'd0};
		v2s_c = {p8h_s2, 32'd0} + {{15{p8l_s2[48]}}, p8l_s2};
	end
	assign v2b_c = $signed(v2s_c) >>> 19;

	// stage 4: square times p9
	always_comb begin
		p9l_c = $signed({1'b0, ss_s3[31:0]}) * $signed(cal.p9);
		p9h_c = ss_s3[63:32] * {{16{cal.p9[15]}}, cal.p9};
	end

	// stage 5: recombine
	assign ssp9_c = {p9h_s4, 32'd0} + {{15{p9l_s4[48]}}, p9l_s4};

	// stage 6: sum of the correction terms
	assign v1c_c = $signed(ssp9_s5) >>> 25;
	assign sum_c = q_s[4] + v1c_c + v2b_s[2];

	// stage 7: scale and offset
	assign sh_c   = $signed(sum_s6) >>> 8;
	assign pfin_c = sh_c + {{44{cal.p7[15]}}, cal.p7, 4'd0};

	// stage 8: status and clamp
	assign pf = $signed(pfin_s7);
	always_comb begin
		if (side_s[6].tsat) begin
			st_c   = ST_TEMP_RANGE;
			pres_c = '0;
		end else if (side_s[6].dzero) begin
			st_c   = ST_DIV_ZERO;
			pres_c = '0;
		end else begin
			st_c = ((pf < P_MIN_Q8) || (pf > P_MAX_Q8)) ? ST_PRES_RANGE : ST_OK;
			if (pf[63]) begin
				pres_c = '0;
			end else if (|pf[62:32]) begin
				pres_c = '1;
			end else begin
				pres_c = pf[31:0];
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[6:0], v_in};
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < 7; k++) begin
				side_s[k] <= side_s[k-1];
			end
			q_s[0] <= q_c;
			for (int k = 1; k < 5; k++) begin
				q_s[k] <= q_s[k-1];
			end
			ll_s2   <= ll_c;
			lh_s2   <= lh_c;
			p8l_s2  <= p8l_c;
			p8h_s2  <= p8h_c;
			ss_s3   <= ss_c;
			v2b_s[0] <= v2b_c;
			v2b_s[1] <= v2b_s[0];
			v2b_s[2] <= v2b_s[1];
			p9l_s4  <= p9l_c;
			p9h_s4  <= p9h_c;
			ssp9_s5 <= ssp9_c;
			sum_s6  <= sum_c;
			pfin_s7 <= pfin_c;
			temp_s8 <= side_s[6].temp;
			pres_s8 <= pres_c;
			st_s8   <= st_c;
		end
	end

	assign v_out    = v_s[7];
	assign temp_out = temp_s8;
	assign pres_out = pres_s8;
	assign stat_out = st_s8;

endmodule

### sv/btpc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the compensation block, bound to the top level.
// Depends on btpc_pkg and baro_temp_pressure_compensation_top_assert.svh.
`include "baro_temp_pressure_compensation_top_assert.svh"

module btpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [btpc_pkg::TEMP_W-1:0]  temperature_centi,
	input logic [btpc_pkg::PRES_W-1:0]         pressure_fixed,
	input logic [btpc_pkg::STAT_W-1:0]         status
);
	import btpc_pkg::*;

	// saturated temperature drops the pressure
	`BTPC_ASSERT_IMPLY(a_tsat_out, clk, arst_n, out_valid && status == ST_TEMP_RANGE, pressure_fixed == '0 && (temperature_centi == TEMP_SAT_HI || temperature_centi == TEMP_SAT_LO))

	// zero divisor gives no pressure
	`BTPC_ASSERT_IMPLY(a_dzero_out, clk, arst_n, out_valid && status == ST_DIV_ZERO, pressure_fixed == '0)

	// a clean status means pressure inside the window
	`BTPC_ASSERT_IMPLY(a_ok_range, clk, arst_n, out_valid && status == ST_OK, pressure_fixed >= PRES_LO_Q8 && pressure_fixed <= PRES_HI_Q8)

	// a stalled result word holds
	`BTPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pressure_fixed) && $stable(status) && $stable(temperature_centi))

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (.*);
